FILE: sv/crb_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the can frame block reassembler
package crb_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ID_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_HIGH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ID    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KIND_MASK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_KIND  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_MASK   = 3'd5;

  typedef enum logic [1:0] {
    OP_BLOCK,
    OP_INLINE,
    OP_STORE
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [7:0]      kind;
    logic [7:0]      sub;
    logic [7:0]      count_ref;
    logic [3:0]      len;
    logic [7:0][7:0] data;
  } cmd_t;

  // queue handshake between classifier and executor
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

FILE: sv/crb_front.sv
`timescale 1ns / 1ps
// frame filter and classifier with the configuration registers
module crb_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [crb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [crb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [10:0]                   can_id_i,
  input  logic [3:0]                    frame_len_i,
  input  logic [7:0][7:0]               payload_i,
  input  crb_pkg::q_stat_t              q_stat_i,
  output logic                          push_o,
  output crb_pkg::cmd_t                 cmd_o
);

  logic [10:0] id_low_q, id_high_q, bcast_q;
  logic [7:0]  kind_mask_q, block_kind_q, flag_mask_q;
  logic [3:0]  len_c;
  logic [7:0]  kind_c;
  logic        hit_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_low_q     <= 11'd0;
      id_high_q    <= 11'd2047;
      bcast_q      <= 11'd0;
      kind_mask_q  <= 8'd127;
      block_kind_q <= 8'd0;
      flag_mask_q  <= 8'd128;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        crb_pkg::CFG_ID_LOW:     id_low_q     <= cfg_data_i;
        crb_pkg::CFG_ID_HIGH:    id_high_q    <= cfg_data_i;
        crb_pkg::CFG_BCAST_ID:   bcast_q      <= cfg_data_i;
        crb_pkg::CFG_KIND_MASK:  kind_mask_q  <= cfg_data_i[7:0];
        crb_pkg::CFG_BLOCK_KIND: block_kind_q <= cfg_data_i[7:0];
        crb_pkg::CFG_FLAG_MASK:  flag_mask_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    hit_c  = ((can_id_i >= id_low_q) && (can_id_i <= id_high_q)) || (can_id_i == bcast_q);
    len_c  = (frame_len_i > 4'd8) ? 4'd8 : frame_len_i;
    kind_c = payload_i[0] & kind_mask_q;

    cmd_o.kind      = kind_c;
    cmd_o.sub       = payload_i[1];
    cmd_o.count_ref = payload_i[2];
    cmd_o.len       = len_c;
    cmd_o.data      = payload_i;
    if (kind_c == block_kind_q) begin
      cmd_o.op = crb_pkg::OP_BLOCK;
    end else if ((payload_i[0] & flag_mask_q) != 8'd0) begin
      cmd_o.op = crb_pkg::OP_STORE;
    end else begin
      cmd_o.op = crb_pkg::OP_INLINE;
    end
  end

  // ignored and short frames are taken and dropped here
  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full && hit_c && (len_c >= 4'd2);

endmodule

FILE: sv/crb_fifo.sv
`timescale 1ns / 1ps
// short command queue between classifier and executor
module crb_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  crb_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output crb_pkg::q_stat_t stat_o,
  output crb_pkg::cmd_t    cmd_o
);

  localparam int PtrW = (crb_pkg::QUEUE_DEPTH > 1) ? $clog2(crb_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(crb_pkg::QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(crb_pkg::QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastP  = PtrW'(crb_pkg::QUEUE_DEPTH - 1);

  crb_pkg::cmd_t   entry_q [crb_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign do_push = push_i && (cnt_q != DepthC);
  assign do_pop  = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastP) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastP) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= cmd_i;
    end
  end

  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == DepthC);
  assign cmd_o        = entry_q[rd_q];

endmodule

FILE: sv/crb_back.sv
`timescale 1ns / 1ps
// command executor: block store, reassembly memory and chunked output
module crb_back #(
  parameter int StoreBytes = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  crb_pkg::q_stat_t q_stat_i,
  input  crb_pkg::cmd_t    cmd_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       msg_kind_o,
  output logic [7:0]       sub_id_o,
  output logic [7:0]       msg_length_o,
  output logic [7:0][7:0]  chunk_o,
  output logic             last_chunk_o
);

  localparam int Rows = (StoreBytes + 7) / 8;
  localparam int RowW = (Rows > 1) ? $clog2(Rows) : 1;
  localparam logic [8:0] Cap = (StoreBytes > 255) ? 9'd255 : 9'(StoreBytes);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_APPEND = 3'd1;
  localparam logic [2:0] ST_INLINE = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [63:0] store_mem [Rows];

  logic [2:0]      state_q, state_d;
  crb_pkg::cmd_t   cmd_q, cmd_d;
  logic [2:0]      idx_q, idx_d;
  logic [7:0]      fill_q, fill_d;
  logic [7:0]      bcnt_q, bcnt_d;
  logic [7:0]      mlen_q, mlen_d;
  logic [4:0]      chunk_q, chunk_d;
  logic [4:0]      last_idx_q, last_idx_d;
  logic [63:0]     rd_q;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      kind_q, kind_d, sub_q, sub_d, len_q, len_d;
  logic [7:0][7:0] bytes_q, bytes_d;
  logic            last_q, last_d;
  logic            slot_free, load, wr_en, rd_en;
  logic [7:0]      pos;
  logic [7:0]      fill_m1;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop_o     = (state_q == ST_IDLE) && q_stat_i.valid;
  assign fill_m1   = fill_q - 8'd1;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    idx_d      = idx_q;
    fill_d     = fill_q;
    bcnt_d     = bcnt_q;
    mlen_d     = mlen_q;
    chunk_d    = chunk_q;
    last_idx_d = last_idx_q;
    kind_d     = kind_q;
    sub_d      = sub_q;
    len_d      = len_q;
    bytes_d    = bytes_q;
    last_d     = last_q;
    load       = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    pos        = '0;

    case (state_q)
      ST_IDLE: begin
        if (q_stat_i.valid) begin
          cmd_d = cmd_i;
          case (cmd_i.op)
            crb_pkg::OP_BLOCK: begin
              idx_d   = 3'd1;
              state_d = ST_APPEND;
            end
            crb_pkg::OP_INLINE: begin
              state_d = ST_INLINE;
            end
            crb_pkg::OP_STORE: begin
              fill_d = '0;
              bcnt_d = '0;
              // count mismatch drops the message but still clears the store
              if (cmd_i.count_ref == bcnt_q) begin
                mlen_d     = fill_q;
                chunk_d    = '0;
                last_idx_d = (fill_q == 8'd0) ? 5'd0 : fill_m1[7:3];
                state_d    = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_APPEND: begin
        if ({1'b0, fill_q} < Cap) begin
          wr_en  = 1'b1;
          fill_d = fill_q + 8'd1;
        end
        idx_d = idx_q + 3'd1;
        if ({1'b0, idx_q} + 4'd1 == cmd_q.len) begin
          bcnt_d  = bcnt_q + 8'd1;
          state_d = ST_IDLE;
        end
      end
      ST_INLINE: begin
        if (slot_free) begin
          load   = 1'b1;
          kind_d = cmd_q.kind;
          sub_d  = cmd_q.sub;
          len_d  = {4'd0, cmd_q.len - 4'd2};
          last_d = 1'b1;
          for (int j = 0; j < 8; j++) begin
            bytes_d[j] = '0;
          end
          for (int j = 0; j < 6; j++) begin
            if (4'(j) < cmd_q.len - 4'd2) begin
              bytes_d[j] = cmd_q.data[j + 2];
            end
          end
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        rd_en   = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          load   = 1'b1;
          kind_d = cmd_q.kind;
          sub_d  = cmd_q.sub;
          len_d  = mlen_q;
          last_d = (chunk_q == last_idx_q);
          for (int j = 0; j < 8; j++) begin
            pos        = {chunk_q, 3'(j)};
            bytes_d[j] = (pos < mlen_q) ? rd_q[j*8 +: 8] : 8'd0;
          end
          if (chunk_q == last_idx_q) begin
            state_d = ST_IDLE;
          end else begin
            chunk_d = chunk_q + 5'd1;
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  // reassembly memory: one byte lane written per cycle, a whole row read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[RowW'(fill_q >> 3)][fill_q[2:0]*8 +: 8] <= cmd_q.data[idx_q];
    end
    if (rd_en) begin
      rd_q <= store_mem[RowW'(chunk_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      bcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      bcnt_q      <= bcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    idx_q      <= idx_d;
    mlen_q     <= mlen_d;
    chunk_q    <= chunk_d;
    last_idx_q <= last_idx_d;
    kind_q     <= kind_d;
    sub_q      <= sub_d;
    len_q      <= len_d;
    bytes_q    <= bytes_d;
    last_q     <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign msg_kind_o   = kind_q;
  assign sub_id_o     = sub_q;
  assign msg_length_o = len_q;
  assign chunk_o      = bytes_q;
  assign last_chunk_o = last_q;

endmodule

FILE: sv/can_frame_block_reassembler.sv
`timescale 1ns / 1ps
// can frame block reassembler top: frame classifier, two-entry command queue, executor
// an inline chunk goes through the queue entry, command register and output register
// a block frame holds the executor while it is dequeued and its data bytes (up to 7) are stored
// a stored message is dequeued, then each 8-byte chunk takes a row read and an output
// load, up to 32 chunks, via the single read port; the queue takes frames meanwhile
// reset restores register defaults, empties queue, fill and count; memory not cleared
module can_frame_block_reassembler #(
  parameter int STORE_BYTES = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [crb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [crb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [10:0]                    can_id_i,
  input  logic [3:0]                     frame_len_i,
  input  logic [7:0]                     payload_0_i,
  input  logic [7:0]                     payload_1_i,
  input  logic [7:0]                     payload_2_i,
  input  logic [7:0]                     payload_3_i,
  input  logic [7:0]                     payload_4_i,
  input  logic [7:0]                     payload_5_i,
  input  logic [7:0]                     payload_6_i,
  input  logic [7:0]                     payload_7_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     msg_kind_o,
  output logic [7:0]                     sub_id_o,
  output logic [7:0]                     msg_length_o,
  output logic [7:0]                     chunk_byte_0_o,
  output logic [7:0]                     chunk_byte_1_o,
  output logic [7:0]                     chunk_byte_2_o,
  output logic [7:0]                     chunk_byte_3_o,
  output logic [7:0]                     chunk_byte_4_o,
  output logic [7:0]                     chunk_byte_5_o,
  output logic [7:0]                     chunk_byte_6_o,
  output logic [7:0]                     chunk_byte_7_o,
  output logic                           last_chunk_o
);

  logic [7:0][7:0]  payload;
  logic [7:0][7:0]  chunk;
  logic             push, pop;
  crb_pkg::cmd_t    cmd_in, cmd_out;
  crb_pkg::q_stat_t q_stat;

  assign payload = {payload_7_i, payload_6_i, payload_5_i, payload_4_i,
                    payload_3_i, payload_2_i, payload_1_i, payload_0_i};

  crb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .can_id_i    (can_id_i),
    .frame_len_i (frame_len_i),
    .payload_i   (payload),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .cmd_o       (cmd_in)
  );

  crb_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (pop),
    .stat_o (q_stat),
    .cmd_o  (cmd_out)
  );

  crb_back #(
    .StoreBytes (STORE_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .cmd_i        (cmd_out),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .msg_kind_o   (msg_kind_o),
    .sub_id_o     (sub_id_o),
    .msg_length_o (msg_length_o),
    .chunk_o      (chunk),
    .last_chunk_o (last_chunk_o)
  );

  assign chunk_byte_0_o = chunk[0];
  assign chunk_byte_1_o = chunk[1];
  assign chunk_byte_2_o = chunk[2];
  assign chunk_byte_3_o = chunk[3];
  assign chunk_byte_4_o = chunk[4];
  assign chunk_byte_5_o = chunk[5];
  assign chunk_byte_6_o = chunk[6];
  assign chunk_byte_7_o = chunk[7];

endmodule

FILE: sv/crb_checker.sv
`timescale 1ns / 1ps
// port checker for the reassembler output channel, bound to the top level
module crb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] msg_length_o,
  input logic [7:0] chunk_byte_0_o,
  input logic [7:0] chunk_byte_7_o,
  input logic       last_chunk_o
);

  // a stalled transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(msg_length_o)
      && $stable(chunk_byte_0_o) && $stable(last_chunk_o))
    else $error("stalled output transaction changed");

  // an empty message is one zero chunk
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (msg_length_o == 8'd0) |-> last_chunk_o && (chunk_byte_0_o == 8'd0))
    else $error("empty message not a single zero chunk");

  // more chunks to follow only for messages longer than one chunk
  a_multi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_chunk_o |-> (msg_length_o > 8'd8))
    else $error("non-final chunk of a short message");

  // a partial last chunk has its top byte zeroed
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_chunk_o && (msg_length_o[2:0] != 3'd0) |-> (chunk_byte_7_o == 8'd0))
    else $error("byte past message length not zero");

endmodule

bind can_frame_block_reassembler crb_checker u_crb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .msg_length_o   (msg_length_o),
  .chunk_byte_0_o (chunk_byte_0_o),
  .chunk_byte_7_o (chunk_byte_7_o),
  .last_chunk_o   (last_chunk_o)
);

FILE: verif/tb_can_frame_block_reassembler.sv
`timescale 1ns / 1ps
// self-checking testbench of can_frame_block_reassembler with a chunk predictor and random traffic
module tb_can_frame_block_reassembler;

  localparam int STORE_BYTES    = 256;
  localparam int STORE_CAP      = (STORE_BYTES > 255) ? 255 : STORE_BYTES;
  localparam int RANDOM_FRAMES  = 420;
  localparam int PHASE_FRAMES   = 40;
  localparam int SETTLE_CYCLES  = 40;
  localparam int IDLE_LIMIT     = 5000;

  typedef struct packed {
    logic [10:0]     id;
    logic [3:0]      len;
    logic [7:0][7:0] pl;
    logic            fix_count;
    logic [7:0]      count_adj;
    logic            drain_first;
  } can_frame_t;

  typedef struct packed {
    logic [7:0]      kind;
    logic [7:0]      sub;
    logic [7:0]      length;
    logic [7:0][7:0] data;
    logic            last;
  } chunk_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [crb_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [crb_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [10:0]                    can_id_i = '0;
  logic [3:0]                     frame_len_i = '0;
  logic [7:0]                     payload_0_i = '0;
  logic [7:0]                     payload_1_i = '0;
  logic [7:0]                     payload_2_i = '0;
  logic [7:0]                     payload_3_i = '0;
  logic [7:0]                     payload_4_i = '0;
  logic [7:0]                     payload_5_i = '0;
  logic [7:0]                     payload_6_i = '0;
  logic [7:0]                     payload_7_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [7:0]                     msg_kind_o;
  logic [7:0]                     sub_id_o;
  logic [7:0]                     msg_length_o;
  logic [7:0]                     chunk_byte_0_o;
  logic [7:0]                     chunk_byte_1_o;
  logic [7:0]                     chunk_byte_2_o;
  logic [7:0]                     chunk_byte_3_o;
  logic [7:0]                     chunk_byte_4_o;
  logic [7:0]                     chunk_byte_5_o;
  logic [7:0]                     chunk_byte_6_o;
  logic [7:0]                     chunk_byte_7_o;
  logic                           last_chunk_o;

  // register mirror
  logic [10:0] id_low_q = 11'd0;
  logic [10:0] id_high_q = 11'd2047;
  logic [10:0] bcast_id_q = 11'd0;
  logic [7:0]  kind_mask_q = 8'd127;
  logic [7:0]  block_kind_q = 8'd0;
  logic [7:0]  flag_mask_q = 8'd128;

  // reassembly state mirror
  logic [7:0] store_mem [256];
  logic [7:0] msg_buf [256];
  int         store_fill = 0;
  logic [7:0] block_cnt = 8'd0;

  can_frame_t pending_frames[$];
  chunk_t     expected_chunks[$];
  can_frame_t cur_frame;
  logic       frame_taken = 1'b0;
  int         sender_gap = 0;
  int         receiver_gap = 0;
  bit         quiet = 1'b0;
  int         useful_frames = 0;
  int         errors = 0;
  int         idle_cycles = 0;

  can_frame_block_reassembler #(
    .STORE_BYTES(STORE_BYTES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .can_id_i      (can_id_i),
    .frame_len_i   (frame_len_i),
    .payload_0_i   (payload_0_i),
    .payload_1_i   (payload_1_i),
    .payload_2_i   (payload_2_i),
    .payload_3_i   (payload_3_i),
    .payload_4_i   (payload_4_i),
    .payload_5_i   (payload_5_i),
    .payload_6_i   (payload_6_i),
    .payload_7_i   (payload_7_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .msg_kind_o    (msg_kind_o),
    .sub_id_o      (sub_id_o),
    .msg_length_o  (msg_length_o),
    .chunk_byte_0_o(chunk_byte_0_o),
    .chunk_byte_1_o(chunk_byte_1_o),
    .chunk_byte_2_o(chunk_byte_2_o),
    .chunk_byte_3_o(chunk_byte_3_o),
    .chunk_byte_4_o(chunk_byte_4_o),
    .chunk_byte_5_o(chunk_byte_5_o),
    .chunk_byte_6_o(chunk_byte_6_o),
    .chunk_byte_7_o(chunk_byte_7_o),
    .last_chunk_o  (last_chunk_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit id_hits(input logic [10:0] id);
    return (id >= id_low_q && id <= id_high_q) || id == bcast_id_q;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // split msg_buf[0 .. len-1] into 8-byte chunks, one chunk for an empty message
  task automatic emit_chunks(input logic [7:0] kind, input logic [7:0] sub, input int len);
    chunk_t c;
    int     n_chunks;
    int     k;
    int     j;
    n_chunks = (len + 7) / 8;
    if (n_chunks == 0) n_chunks = 1;
    for (k = 0; k < n_chunks; k++) begin
      c.kind = kind;
      c.sub = sub;
      c.length = len[7:0];
      for (j = 0; j < 8; j++) c.data[j] = (k * 8 + j < len) ? msg_buf[k * 8 + j] : 8'h00;
      c.last = (k == n_chunks - 1);
      expected_chunks.push_back(c);
    end
  endtask

  task automatic compute_chunks(input can_frame_t f);
    int         n;
    int         i;
    logic [7:0] kind;
    n = (f.len > 8) ? 8 : int'(f.len);
    if (!id_hits(f.id) || n < 2) return;
    kind = f.pl[0] & kind_mask_q;
    if (kind == block_kind_q) begin
      for (i = 1; i < n; i++) begin
        if (store_fill < STORE_CAP) begin
          store_mem[store_fill] = f.pl[i];
          store_fill++;
        end
      end
      block_cnt = block_cnt + 8'd1;
      return;
    end
    if ((f.pl[0] & flag_mask_q) != 8'h00) begin
      // end of block transfer: deliver only on matching block count
      if (f.pl[2] == block_cnt) begin
        for (i = 0; i < store_fill; i++) msg_buf[i] = store_mem[i];
        emit_chunks(kind, f.pl[1], store_fill);
      end
      store_fill = 0;
      block_cnt = 8'd0;
      return;
    end
    for (i = 2; i < n; i++) msg_buf[i - 2] = f.pl[i];
    emit_chunks(kind, f.pl[1], n - 2);
  endtask

  task automatic flag_mismatch(input string field, input logic [7:0] want,
                               input logic [7:0] seen);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
    errors++;
  endtask

  // frame driver
  always @(negedge clk_i) begin : frame_driver
    can_frame_t f;
    if (rst_ni && (!in_valid_i || frame_taken)) begin
      if (sender_gap > 0) begin
        sender_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_frames.size() != 0 &&
                   (!pending_frames[0].drain_first || expected_chunks.size() == 0)) begin
        f = pending_frames.pop_front();
        // block count known here since every earlier frame has been taken
        if (f.fix_count) f.pl[2] = block_cnt + f.count_adj;
        cur_frame = f;
        can_id_i <= f.id;
        frame_len_i <= f.len;
        payload_0_i <= f.pl[0];
        payload_1_i <= f.pl[1];
        payload_2_i <= f.pl[2];
        payload_3_i <= f.pl[3];
        payload_4_i <= f.pl[4];
        payload_5_i <= f.pl[5];
        payload_6_i <= f.pl[6];
        payload_7_i <= f.pl[7];
        in_valid_i <= 1'b1;
        sender_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result stall
  always @(negedge clk_i) begin : result_stall
    if (receiver_gap == 0 && $urandom_range(3, 0) == 0) receiver_gap = pick_gap();
    if (receiver_gap > 0) begin
      out_stall_i <= 1'b1;
      receiver_gap--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor, predictor update and watchdog
  always @(posedge clk_i) begin : chunk_monitor
    chunk_t got;
    chunk_t want;
    int     j;
    if (rst_ni) begin
      frame_taken = in_valid_i && !in_stall_o;
      if (frame_taken) compute_chunks(cur_frame);
      if (out_valid_o && !out_stall_i) begin
        got.kind = msg_kind_o;
        got.sub = sub_id_o;
        got.length = msg_length_o;
        got.data = {chunk_byte_7_o, chunk_byte_6_o, chunk_byte_5_o, chunk_byte_4_o,
                    chunk_byte_3_o, chunk_byte_2_o, chunk_byte_1_o, chunk_byte_0_o};
        got.last = last_chunk_o;
        if (expected_chunks.size() == 0) begin
          $display("%0t: unexpected chunk, kind %0h sub %0h length %0d", $time,
                   got.kind, got.sub, got.length);
          errors++;
        end else begin
          want = expected_chunks.pop_front();
          if (got.kind !== want.kind) flag_mismatch("msg_kind", want.kind, got.kind);
          if (got.sub !== want.sub) flag_mismatch("sub_id", want.sub, got.sub);
          if (got.length !== want.length) flag_mismatch("msg_length", want.length, got.length);
          for (j = 0; j < 8; j++) begin
            if (got.data[j] !== want.data[j])
              flag_mismatch($sformatf("chunk_byte_%0d", j), want.data[j], got.data[j]);
          end
          if (got.last !== want.last) flag_mismatch("last_chunk", want.last, got.last);
        end
      end
      if (frame_taken || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
          $display("tb_can_frame_block_reassembler NOT OK");
          $finish;
        end
      end
    end
  end

  task automatic push_frame(input logic [10:0] id, input logic [3:0] len, input logic [63:0] pl,
                            input logic fix, input logic [7:0] adj, input logic drain);
    can_frame_t f;
    f.id = id;
    f.len = len;
    f.pl = pl;
    f.fix_count = fix;
    f.count_adj = adj;
    f.drain_first = drain;
    if (id_hits(id) && len >= 2) useful_frames++;
    pending_frames.push_back(f);
  endtask

  task automatic drain_and_settle();
    while (pending_frames.size() != 0 || in_valid_i || expected_chunks.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [crb_pkg::CFG_IDX_W-1:0] idx, input logic [10:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      crb_pkg::CFG_ID_LOW:     id_low_q = val;
      crb_pkg::CFG_ID_HIGH:    id_high_q = val;
      crb_pkg::CFG_BCAST_ID:   bcast_id_q = val;
      crb_pkg::CFG_KIND_MASK:  kind_mask_q = val[7:0];
      crb_pkg::CFG_BLOCK_KIND: block_kind_q = val[7:0];
      crb_pkg::CFG_FLAG_MASK:  flag_mask_q = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // 8-bit registers get junk in the upper data bits
  task automatic set_config(input logic [10:0] low, input logic [10:0] high,
                            input logic [10:0] bcast, input logic [7:0] km,
                            input logic [7:0] bk, input logic [7:0] fm);
    write_reg(crb_pkg::CFG_ID_LOW, low);
    write_reg(crb_pkg::CFG_ID_HIGH, high);
    write_reg(crb_pkg::CFG_BCAST_ID, bcast);
    write_reg(crb_pkg::CFG_KIND_MASK, {3'($urandom), km});
    write_reg(crb_pkg::CFG_BLOCK_KIND, {3'($urandom), bk});
    write_reg(crb_pkg::CFG_FLAG_MASK, {3'($urandom), fm});
  endtask

  function automatic logic [10:0] pick_id();
    if (id_low_q <= id_high_q && $urandom_range(3, 0) != 0)
      return 11'($urandom_range(int'(id_high_q), int'(id_low_q)));
    return bcast_id_q;
  endfunction

  function automatic logic [3:0] pick_len();
    int r;
    r = $urandom_range(99, 0);
    if (r < 5) return 4'($urandom_range(1, 0));
    if (r < 12) return 4'($urandom_range(15, 9));
    return 4'($urandom_range(8, 2));
  endfunction

  function automatic logic [63:0] rand_bytes();
    return {$urandom, $urandom};
  endfunction

  // byte 0 of a frame that ends a block transfer, or of an inline message
  function automatic logic [7:0] finish_p0(input bit with_flag);
    logic [7:0] p0;
    int         tries;
    p0 = 8'($urandom);
    for (tries = 0; tries < 64; tries++) begin
      if ((p0 & kind_mask_q) != block_kind_q &&
          (((p0 & flag_mask_q) != 8'h00) == with_flag)) break;
      p0 = 8'($urandom);
    end
    return p0;
  endfunction

  task automatic gen_transfer(input int n_blocks);
    logic [63:0] pl;
    int          b;
    for (b = 0; b < n_blocks; b++) begin
      pl = rand_bytes();
      pl[7:0] = (8'($urandom) & ~kind_mask_q) | block_kind_q;
      push_frame(pick_id(), pick_len(), pl, 1'b0, 8'd0, 1'b0);
    end
    pl = rand_bytes();
    pl[7:0] = finish_p0(1'b1);
    push_frame(pick_id(), pick_len(), pl, 1'b1,
               ($urandom_range(9, 0) == 0) ? 8'($urandom_range(255, 1)) : 8'd0,
               $urandom_range(19, 0) == 0);
  endtask

  task automatic gen_random_step();
    logic [63:0] pl;
    int          r;
    r = $urandom_range(99, 0);
    if (r < 55) begin
      gen_transfer(($urandom_range(9, 0) == 0) ? $urandom_range(40, 30) : $urandom_range(6, 0));
    end else if (r < 85) begin
      pl = rand_bytes();
      pl[7:0] = finish_p0(1'b0);
      push_frame(pick_id(), pick_len(), pl, 1'b0, 8'd0, 1'b0);
    end else begin
      push_frame(11'($urandom), 4'($urandom), rand_bytes(), 1'b0, 8'd0, 1'b0);
    end
  endtask

  initial begin
    int start_cnt;
    int phase_cnt;
    int phase;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration: inline extremes, short and long length codes
    push_frame(11'd0, 4'd8, 64'hFFFF_FFFF_FFFF_FF7F, 1'b0, 8'd0, 1'b0);
    push_frame(11'd2047, 4'd8, 64'h0000_0000_0000_0001, 1'b0, 8'd0, 1'b0);
    push_frame(11'd5, 4'd2, 64'h1234_5678_9ABC_AA01, 1'b0, 8'd0, 1'b0);
    push_frame(11'd5, 4'd0, 64'h1111_1111_1111_1101, 1'b0, 8'd0, 1'b0);
    push_frame(11'd5, 4'd1, 64'h2222_2222_2222_2201, 1'b0, 8'd0, 1'b0);
    push_frame(11'd7, 4'd15, 64'hA5C3_5A3C_0FF0_117E, 1'b0, 8'd0, 1'b0);
    push_frame(11'd7, 4'd9, 64'h0102_0304_0506_0702, 1'b0, 8'd0, 1'b0);
    // block transfer, flag bit on a block kind still counts as block
    push_frame(11'd9, 4'd8, 64'hFFFF_FFFF_FFFF_FF00, 1'b0, 8'd0, 1'b0);
    push_frame(11'd9, 4'd8, 64'h8877_6655_4433_2280, 1'b0, 8'd0, 1'b0);
    push_frame(11'd9, 4'd2, 64'h0000_0000_0000_5A00, 1'b0, 8'd0, 1'b0);
    push_frame(11'd9, 4'd1, 64'h0000_0000_0000_EE00, 1'b0, 8'd0, 1'b0);
    push_frame(11'd9, 4'd3, 64'h0000_0000_0003_3381, 1'b0, 8'd0, 1'b0);
    // failed transfer clears the store
    push_frame(11'd9, 4'd5, 64'h0000_00DD_CCBB_AA00, 1'b0, 8'd0, 1'b0);
    push_frame(11'd9, 4'd8, 64'h0000_0000_0009_44FF, 1'b0, 8'd0, 1'b0);
    // empty transfer delivers an empty message
    push_frame(11'd9, 4'd8, 64'h0000_0000_0000_5585, 1'b0, 8'd0, 1'b0);
    push_frame(11'd9, 4'd4, 64'h0000_0000_7766_0055, 1'b0, 8'd0, 1'b1);
    drain_and_settle();

    // identifier window with broadcast
    set_config(11'd100, 11'd200, 11'd2047, 8'hFF, 8'hFF, 8'h01);
    push_frame(11'd99, 4'd8, 64'h0123_4567_89AB_CD02, 1'b0, 8'd0, 1'b0);
    push_frame(11'd201, 4'd8, 64'h0123_4567_89AB_CD02, 1'b0, 8'd0, 1'b0);
    push_frame(11'd100, 4'd3, 64'h0000_0000_00C1_B202, 1'b0, 8'd0, 1'b0);
    push_frame(11'd200, 4'd8, 64'h7172_7374_7576_77FF, 1'b0, 8'd0, 1'b0);
    push_frame(11'd2047, 4'd8, 64'h0000_0000_0001_6601, 1'b0, 8'd0, 1'b0);
    push_frame(11'd0, 4'd8, 64'h0000_0000_0000_0002, 1'b0, 8'd0, 1'b0);
    drain_and_settle();

    start_cnt = useful_frames;
    phase = 0;
    while (useful_frames - start_cnt < RANDOM_FRAMES) begin
      quiet = (phase % 3 == 2);
      case (phase)
        0: set_config(11'd0, 11'd2047, 11'd0, 8'hFF, 8'h00, 8'h00);
        1: set_config(11'd2047, 11'd0, 11'd5, 8'h00, 8'h55, 8'hFF);
        2: begin
          set_config(11'd0, 11'd2047, 11'd0, 8'h7F, 8'h00, 8'h80);
          // store saturation and block count wrap in one transfer
          gen_transfer(257);
        end
        default: begin
          kind_mask_q = 8'($urandom);
          set_config(11'($urandom_range(1024, 0)), 11'($urandom_range(2047, 1024)),
                     11'($urandom), kind_mask_q, 8'($urandom) & kind_mask_q,
                     8'($urandom) | 8'h01);
        end
      endcase
      phase_cnt = useful_frames;
      while (useful_frames - phase_cnt < PHASE_FRAMES &&
             useful_frames - start_cnt < RANDOM_FRAMES)
        gen_random_step();
      drain_and_settle();
      phase++;
    end

    if (errors == 0 && expected_chunks.size() == 0) begin
      $display("tb_can_frame_block_reassembler OK");
    end else begin
      $display("tb_can_frame_block_reassembler NOT OK");
    end
    $finish;
  end

endmodule

FILE: can_frame_block_reassembler.f
sv/crb_pkg.sv
sv/crb_front.sv
sv/crb_fifo.sv
sv/crb_back.sv
sv/can_frame_block_reassembler.sv
sv/crb_checker.sv
verif/tb_can_frame_block_reassembler.sv
